// File: sv/uihc_pkg.sv
// Shared types, codes and constants for the UDP/IPv4 frame header check.
`timescale 1ns / 1ps
`default_nettype none
package uihc_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned DEF_MAX_FRAME_BYTES = 65535;

  localparam logic [1:0] LINK_LOOPBACK = 2'd0;
  localparam logic [1:0] LINK_ETHERNET = 2'd1;
  localparam logic [1:0] LINK_SLIP     = 2'd2;
  localparam logic [1:0] LINK_PPP      = 2'd3;

  localparam logic [4:0] LINK_HDR_LOOPBACK = 5'd4;
  localparam logic [4:0] LINK_HDR_ETHERNET = 5'd14;
  localparam logic [4:0] LINK_HDR_SERIAL   = 5'd24;

  localparam logic [15:0] ETH_POS_TYPE_HI = 16'd12;
  localparam logic [15:0] ETH_POS_TYPE_LO = 16'd13;
  localparam logic [15:0] IP_POS_FIRST    = 16'd0;
  localparam logic [15:0] IP_POS_PROTO    = 16'd9;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [6:0]  IP_MIN_HEADER  = 7'd20;
  localparam logic [6:0]  UDP_HEADER     = 7'd8;
  localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;

  localparam logic [2:0] VERDICT_OK_UDP      = 3'd0;
  localparam logic [2:0] VERDICT_NOT_IP      = 3'd1;
  localparam logic [2:0] VERDICT_TOO_SHORT   = 3'd2;
  localparam logic [2:0] VERDICT_BAD_VERSION = 3'd3;
  localparam logic [2:0] VERDICT_BAD_HLEN    = 3'd4;
  localparam logic [2:0] VERDICT_SHORT_UDP   = 3'd5;
  localparam logic [2:0] VERDICT_CSUM_ERR    = 3'd6;
  localparam logic [2:0] VERDICT_NOT_UDP     = 3'd7;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [5:0]  ip_header_bytes;
    logic [4:0]  link_header_bytes;
    logic [2:0]  verdict;
  } result_t;

endpackage
`default_nettype wire

// File: sv/uihc_parse.sv
// Per-byte header tracking, checksum accumulation and verdict logic.
`timescale 1ns / 1ps
`default_nettype none
module uihc_parse #(
  parameter int unsigned MAX_FRAME_BYTES = uihc_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [7:0]        frame_byte,
  input  wire logic              frame_last,
  input  wire logic [1:0]        link_type,
  output uihc_pkg::result_t      res_nxt
);
  import uihc_pkg::*;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      csum_r, csum_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [15:0]      etype_r, etype_nxt;
  logic [3:0]       ver_r, ver_nxt;
  logic [3:0]       hw_r, hw_nxt;
  logic [7:0]       proto_r, proto_nxt;

  always_comb begin
    logic [4:0]       lh;
    logic [POS_W-1:0] p;
    logic [16:0]      s;
    logic [5:0]       hlen;
    logic [15:0]      len;
    logic [2:0]       verdict;

    case (link_type)
      LINK_LOOPBACK: lh = LINK_HDR_LOOPBACK;
      LINK_ETHERNET: lh = LINK_HDR_ETHERNET;
      default:       lh = LINK_HDR_SERIAL;
    endcase

    pos_nxt   = pos_r;
    csum_nxt  = csum_r;
    pend_nxt  = pend_r;
    etype_nxt = etype_r;
    ver_nxt   = ver_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    p         = pos_r - POS_W'(lh);
    s         = {1'b0, csum_r} + {1'b0, pend_r, frame_byte};

    if (pos_r < MAX_POS) begin
      pos_nxt = pos_r + POS_W'(1);
      if (link_type == LINK_ETHERNET) begin
        if (pos_r == ETH_POS_TYPE_HI) etype_nxt = {frame_byte, etype_r[7:0]};
        else if (pos_r == ETH_POS_TYPE_LO) etype_nxt = {etype_r[15:8], frame_byte};
      end
      if (pos_r >= POS_W'(lh)) begin
        if (p == IP_POS_FIRST) begin
          ver_nxt = frame_byte[7:4];
          hw_nxt  = frame_byte[3:0];
        end else if (p == IP_POS_PROTO) begin
          proto_nxt = frame_byte;
        end
        if (p < POS_W'({hw_nxt, 2'b00})) begin
          if (!p[0]) begin
            pend_nxt = frame_byte;
          end else begin
            csum_nxt = s[16] ? (s[15:0] + 16'd1) : s[15:0];
          end
        end
      end
    end

    hlen = {hw_nxt, 2'b00};
    len  = (pos_nxt > POS_W'(lh)) ? 16'(pos_nxt - POS_W'(lh)) : 16'd0;

    if (link_type == LINK_ETHERNET && etype_nxt != ETHERTYPE_IPV4)
      verdict = VERDICT_NOT_IP;
    else if (len < 16'(IP_MIN_HEADER + UDP_HEADER))
      verdict = VERDICT_TOO_SHORT;
    else if (ver_nxt != IP_VERSION_4)
      verdict = VERDICT_BAD_VERSION;
    else if ({1'b0, hlen} < IP_MIN_HEADER)
      verdict = VERDICT_BAD_HLEN;
    else if (len < 16'({1'b0, hlen} + UDP_HEADER))
      verdict = VERDICT_SHORT_UDP;
    else if (csum_nxt != CSUM_GOOD)
      verdict = VERDICT_CSUM_ERR;
    else if (proto_nxt != PROTO_UDP)
      verdict = VERDICT_NOT_UDP;
    else
      verdict = VERDICT_OK_UDP;

    res_nxt.verdict           = verdict;
    res_nxt.link_header_bytes = lh;
    res_nxt.ip_header_bytes   = hlen;
    res_nxt.frame_length      = len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && frame_last)) begin
      pos_r   <= '0;
      csum_r  <= '0;
      pend_r  <= '0;
      etype_r <= '0;
      ver_r   <= '0;
      hw_r    <= '0;
      proto_r <= '0;
    end else if (en) begin
      pos_r   <= pos_nxt;
      csum_r  <= csum_nxt;
      pend_r  <= pend_nxt;
      etype_r <= etype_nxt;
      ver_r   <= ver_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/udp_ipv4_frame_header_check.sv
// Top level of the UDP/IPv4 frame header check: input stage, parser and result register.
//
//  channel | dir | signals                         | content
//  in_     | in  | tvalid tready tdata[7:0] tlast  | one frame byte a request, tlast on the final byte
//  out_    | out | tvalid tready tdata[31:0]       | one verdict per frame
//  cfg_    | in  | wr_en wr_data[1:0]              | link type
//
//  One byte a cycle sustained unless a last byte waits on a stalled verdict: each request
//  is held in the input register and is folded into the header state by the parser as it leaves it.
//  A verdict is loaded into the result register at the edge where its last byte leaves
//  the input stage.
//  Reset clears the frame state and sets link type to ethernet; no clearing pass.
//  A stalled verdict holds the input stage only when the waiting byte is itself a last byte.
`timescale 1ns / 1ps
`default_nettype none
module udp_ipv4_frame_header_check #(
  parameter int unsigned MAX_FRAME_BYTES = uihc_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire logic        in_tlast,   // frame_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [2:0] verdict, [7:3] link_header_bytes,
                                       // [13:8] ip_header_bytes, [29:14] frame_length, [31:30] zero
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data
);
  import uihc_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_advance;
  logic [1:0]  link_type_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;

  assign s1_advance = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= LINK_ETHERNET;
    end else if (cfg_wr_en) begin
      link_type_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  uihc_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_advance),
    .frame_byte(s1_byte_r),
    .frame_last(s1_last_r),
    .link_type (link_type_r),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_last_r) |=> out_valid_r)
    else $error("last byte left the input stage without a verdict");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a waiting verdict");

  a_link_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.link_header_bytes == LINK_HDR_LOOPBACK ||
                     res_r.link_header_bytes == LINK_HDR_ETHERNET ||
                     res_r.link_header_bytes == LINK_HDR_SERIAL))
    else $error("link header length out of set");

  a_ok_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.verdict == VERDICT_OK_UDP) |->
      ({1'b0, res_r.ip_header_bytes} >= IP_MIN_HEADER &&
       res_r.frame_length >= 16'({1'b0, res_r.ip_header_bytes} + UDP_HEADER)))
    else $error("ok verdict with inconsistent sizes");

endmodule
`default_nettype wire
